// ===== design/ttl_pkg.sv =====
// shared types and constants for the address lifetime table
package ttl_pkg;

    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int REMOVED_W = 5;
    localparam int ADDR_W    = 32;
    localparam int TOKEN_W   = 32;
    localparam int LIFE_W    = 16;

    localparam logic [LIFE_W-1:0] RELOAD_RESET = 16'd300;

    localparam logic KIND_AUTH = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REFRESHED = 2'd0,
        ST_CREATED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_TICK      = 2'd3
    } t_status;

endpackage

// ===== design/ttl_address_table.sv =====
// Address table with per-entry lifetime, top level.
// Input channel (i_in_valid / o_in_ready) takes one word: i_kind selects an
// authorize of i_address (new entries also store i_new_token) or one tick
// that ages all occupied entries. Output channel (o_out_valid / i_out_ready)
// returns one word per input: status, slot and removed entry count.
// i_cfg_wr_en writes the lifetime reload value; write it only while idle, as
// the block itself does not enforce this. Each word is handled by one sweep
// over the entry memory through its single read port, then a drain state and
// a finish state that registers the result; the next word can be accepted
// only in the cycle after. Ticks write back aged entries during the sweep; an
// authorize that found a hit or an empty slot writes its entry once the sweep
// is done. The output register holds a finished result while the receiver
// stalls; a new word is taken meanwhile, and its sweep waits at the end until
// the output register frees up. Reset empties every entry at once through
// per-entry valid bits and sets the reload value to 300.
module ttl_address_table
    import ttl_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [LIFE_W-1:0]    i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [TOKEN_W-1:0]   i_new_token,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [REMOVED_W-1:0] o_removed_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic                r_kind;
    logic [ADDR_W-1:0]   r_address;
    logic [TOKEN_W-1:0]  r_token;
    logic [LIFE_W-1:0]   r_reload;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_chk_vld;
    logic [IDX_W-1:0]    r_chk_idx;
    logic                r_hit_found;
    logic [IDX_W-1:0]    r_hit_idx;
    logic                r_empty_found;
    logic [IDX_W-1:0]    r_empty_idx;
    logic [CNT_W-1:0]    r_removed;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [REMOVED_W-1:0] r_out_removed;

    logic [ADDR_W-1:0]   rd_address;
    logic [LIFE_W-1:0]   rd_lifetime;
    logic                out_free;
    logic                commit;
    logic                is_hit;
    logic                is_empty;
    logic                expire;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [ADDR_W-1:0]   wr_address;
    logic [LIFE_W-1:0]   wr_lifetime;
    logic                wr_token_en;
    logic                clr_en;

    ttl_entry_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (r_state == S_SCAN),
        .i_rd_idx      (r_rd_idx),
        .o_rd_address  (rd_address),
        .o_rd_lifetime (rd_lifetime),
        .i_wr_en       (wr_en),
        .i_wr_idx      (wr_idx),
        .i_wr_address  (wr_address),
        .i_wr_lifetime (wr_lifetime),
        .i_wr_token_en (wr_token_en),
        .i_wr_token    (r_token),
        .i_clr_en      (clr_en),
        .i_clr_idx     (r_chk_idx)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign is_hit   = (rd_address == r_address);
    assign is_empty = (rd_address == '0);
    assign expire   = (rd_lifetime <= LIFE_W'(1));

    // authorize writes once at the end; ticks write back during the sweep
    assign commit = (r_state == S_FINISH) && out_free && (r_kind == KIND_AUTH)
                    && (r_hit_found || r_empty_found);

    always_comb begin
        wr_en       = 1'b0;
        wr_idx      = r_chk_idx;
        wr_address  = rd_address;
        wr_lifetime = rd_lifetime - LIFE_W'(1);
        wr_token_en = 1'b0;
        clr_en      = 1'b0;
        if (commit) begin
            wr_en       = 1'b1;
            wr_idx      = r_hit_found ? r_hit_idx : r_empty_idx;
            wr_address  = r_address;
            wr_lifetime = r_reload;
            wr_token_en = !r_hit_found;
        end else if (r_chk_vld && (r_kind == KIND_TICK) && !is_empty) begin
            wr_en  = !expire;
            clr_en = expire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_removed   <= '0;
            r_reload    <= RELOAD_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_reload <= i_cfg_wr_data;
            end
            // a finished result refills the output register as the old one leaves
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            r_chk_vld <= (r_state == S_SCAN);
            r_chk_idx <= r_rd_idx;

            // lookup checks run in the cycle after the read, on the registered read data
            if (r_chk_vld) begin
                if (r_kind == KIND_AUTH) begin
                    if (is_hit && !r_hit_found) begin
                        r_hit_found <= 1'b1;
                        r_hit_idx   <= r_chk_idx;
                    end
                    if (is_empty && !r_empty_found) begin
                        r_empty_found <= 1'b1;
                        r_empty_idx   <= r_chk_idx;
                    end
                end else if (!is_empty && expire) begin
                    r_removed <= r_removed + CNT_W'(1);
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind        <= i_kind;
                        r_address     <= i_address;
                        r_token       <= i_new_token;
                        r_rd_idx      <= '0;
                        r_hit_found   <= 1'b0;
                        r_empty_found <= 1'b0;
                        r_removed     <= '0;
                        r_state       <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                    if (r_rd_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        if (r_kind == KIND_TICK) begin
                            r_out_status  <= ST_TICK;
                            r_out_slot    <= '0;
                            r_out_removed <= REMOVED_W'(r_removed);
                        end else if (r_hit_found) begin
                            r_out_status  <= ST_REFRESHED;
                            r_out_slot    <= SLOT_W'(r_hit_idx);
                            r_out_removed <= '0;
                        end else if (r_empty_found) begin
                            r_out_status  <= ST_CREATED;
                            r_out_slot    <= SLOT_W'(r_empty_idx);
                            r_out_removed <= '0;
                        end else begin
                            r_out_status  <= ST_FULL;
                            r_out_slot    <= '0;
                            r_out_removed <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot          = r_out_slot;
    assign o_removed_count = r_out_removed;

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SCAN))
        else $error("accepted word did not start a sweep");

    a_no_check_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_chk_vld)
        else $error("lookup still in flight while ready");

    a_removed_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_removed <= CNT_W'(ENTRIES))
        else $error("removed count exceeds table size");

    a_tick_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_TICK)) |-> (o_slot == '0))
        else $error("tick result carries a slot");

    a_auth_no_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_TICK)) |-> (o_removed_count == '0))
        else $error("authorize result carries a removed count");
`endif

endmodule

// ===== design/ttl_entry_store.sv =====
// entry memories (address, lifetime, token) with per-entry valid bits
module ttl_entry_store
    import ttl_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [ADDR_W-1:0] o_rd_address,
    output logic [LIFE_W-1:0] o_rd_lifetime,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  logic [ADDR_W-1:0] i_wr_address,
    input  logic [LIFE_W-1:0] i_wr_lifetime,
    input  logic              i_wr_token_en,
    input  logic [TOKEN_W-1:0] i_wr_token,
    input  logic              i_clr_en,
    input  logic [IDX_W-1:0]  i_clr_idx
);

    logic [ADDR_W-1:0]  mem_address  [ENTRIES];
    logic [LIFE_W-1:0]  mem_lifetime [ENTRIES];
    logic [TOKEN_W-1:0] mem_token    [ENTRIES];

    logic [ENTRIES-1:0] r_valid;
    logic               r_rd_valid;
    logic [ADDR_W-1:0]  r_rd_address;
    logic [LIFE_W-1:0]  r_rd_lifetime;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_address[i_wr_idx]  <= i_wr_address;
            mem_lifetime[i_wr_idx] <= i_wr_lifetime;
        end
        if (i_wr_token_en) begin
            mem_token[i_wr_idx] <= i_wr_token;
        end
        if (i_rd_en) begin
            r_rd_address  <= mem_address[i_rd_idx];
            r_rd_lifetime <= mem_lifetime[i_rd_idx];
        end
    end

    // an entry never written since reset, or expired, reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_clr_en) begin
                r_valid[i_clr_idx] <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_address  = r_rd_valid ? r_rd_address : '0;
    assign o_rd_lifetime = r_rd_valid ? r_rd_lifetime : '0;

endmodule
